### hw/rtl/assert_macros.svh
// Assertion macros shared by the palette unit modules.
// Each use expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define IPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("palette unit assertion failed");
// Checked at every edge, reset included.
`define IPR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("palette unit assertion failed");
`else
`define IPR_ASSERT(lbl, prop)
`define IPR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/ipr_pkg.sv
// Package of the indexed palette RAM unit: types, codes and the color decode.
// No dependencies; ipr_ctrl, ipr_out and the top level use it.
package ipr_pkg;

    // Default palette RAM size in bytes per bank.
    localparam int PALETTE_BYTES_DEF = 64;
    localparam int PTR_W = 7;
    localparam int PTR_MAX = 64;

    // Operation codes of an input word.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [4:0] CHAN_FULL = 5'd31;

    // Register selector codes; code 7 is unused and does nothing.
    typedef enum logic [2:0] {
        SEL_BG_SHADE   = 3'd0,
        SEL_OBJ0_SHADE = 3'd1,
        SEL_OBJ1_SHADE = 3'd2,
        SEL_BG_INDEX   = 3'd3,
        SEL_BG_DATA    = 3'd4,
        SEL_OBJ_INDEX  = 3'd5,
        SEL_OBJ_DATA   = 3'd6
    } reg_sel_t;

    // One accepted input word.
    typedef struct packed {
        logic       op;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [3:0] palette_number;
        logic [1:0] color_index;
    } item_t;

    // Byte write into the low or high byte RAM.
    typedef struct packed {
        logic       lo_we;
        logic       hi_we;
        logic [7:0] data;
    } ram_wr_t;

    // Lookup side information that travels with the RAM read.
    typedef struct packed {
        logic       is_lookup;
        logic       color;
        logic       white;
        logic       lo_ok;
        logic       hi_ok;
        logic [1:0] shade;
    } lkup_t;

    typedef struct packed {
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
    } rgb_t;

    // Little-endian byte pair to RGB555; bit 7 of the high byte is unused.
    function automatic rgb_t decode_pair(input logic [7:0] lo, input logic [6:0] hi);
        rgb_t c;
        c.r = lo[4:0];
        c.g = {hi[1:0], lo[7:5]};
        c.b = hi[6:2];
        return c;
    endfunction

endpackage

### hw/rtl/ipr_if.sv
// Handshake channel interfaces of the palette unit: request, result, config.
// No dependencies.

// Request channel: one register write or one pixel lookup per word.
interface ipr_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [3:0] palette_number;
    logic [1:0] color_index;

    modport source (output valid, output op, output reg_select, output write_data,
                    output palette_number, output color_index, input ready);
    modport sink (input valid, input op, input reg_select, input write_data,
                  input palette_number, input color_index, output ready);
endinterface

// Result channel: one word per request.
interface ipr_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic [1:0] shade;

    modport source (output valid, output red, output green, output blue,
                    output shade, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input shade, output ready);
endinterface

// Configuration write channel for the color mode register.
interface ipr_cfg_if;
    logic valid;
    logic ready;
    logic color_mode;

    modport source (output valid, output color_mode, input ready);
    modport sink (input valid, input color_mode, output ready);
endinterface

### hw/rtl/ipr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/ipr_ctrl.sv
// Palette register control: byte pointers, shade map, color mode and the
// written-byte valid bits. Depends on ipr_pkg, ipr_if and assert_macros.svh.
`include "assert_macros.svh"

module ipr_ctrl #(
    parameter int PALETTE_BYTES = ipr_pkg::PALETTE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ipr_cfg_if.sink              cfg,
    input  logic                 fire,
    input  ipr_pkg::item_t       item,
    output ipr_pkg::ram_wr_t     wr,
    output logic [$clog2(2 * ((PALETTE_BYTES + 1) / 2))-1:0] wr_addr,
    output logic [$clog2(2 * ((PALETTE_BYTES + 1) / 2))-1:0] rd_addr,
    output ipr_pkg::lkup_t       info
);

    localparam int PAIRS = (PALETTE_BYTES + 1) / 2;
    localparam int DEPTH = 2 * PAIRS;
    localparam int AW = $clog2(DEPTH);
    localparam logic [ipr_pkg::PTR_W-1:0] PTR_LIMIT = ipr_pkg::PTR_W'(PALETTE_BYTES);

    logic                        color_mode_reg;
    logic [ipr_pkg::PTR_W-1:0]   bg_ptr_reg, bg_ptr_next;
    logic [ipr_pkg::PTR_W-1:0]   obj_ptr_reg, obj_ptr_next;
    logic                        bg_inc_reg, bg_inc_next;
    logic                        obj_inc_reg, obj_inc_next;
    logic [2:0][3:0][1:0]        shade_reg, shade_next;
    logic [DEPTH-1:0]            lo_valid_reg, lo_valid_next;
    logic [DEPTH-1:0]            hi_valid_reg, hi_valid_next;

    ipr_pkg::reg_sel_t           sel;
    logic                        is_write;
    logic                        data_wr;
    logic                        obj_side;
    logic [ipr_pkg::PTR_W-1:0]   bg_ptr_eff, obj_ptr_eff, ptr_eff;
    logic                        inc_sel;
    logic [4:0]                  wr_pair;
    logic [4:0]                  lk_pair;
    logic                        lk_in_range;
    logic [1:0]                  mono_pal;

    assign cfg.ready = 1'b1;

    // Color mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            color_mode_reg <= cfg.color_mode;
        end
    end

    // Data write decode: a pointer past the RAM wraps to zero first.
    assign sel         = ipr_pkg::reg_sel_t'(item.reg_select);
    assign is_write    = fire && (item.op == ipr_pkg::OP_WRITE);
    assign obj_side    = (sel == ipr_pkg::SEL_OBJ_DATA);
    assign data_wr     = is_write && ((sel == ipr_pkg::SEL_BG_DATA) || obj_side);
    assign bg_ptr_eff  = (bg_ptr_reg >= PTR_LIMIT) ? '0 : bg_ptr_reg;
    assign obj_ptr_eff = (obj_ptr_reg >= PTR_LIMIT) ? '0 : obj_ptr_reg;
    assign ptr_eff     = obj_side ? obj_ptr_eff : bg_ptr_eff;
    assign inc_sel     = obj_side ? obj_inc_reg : bg_inc_reg;
    assign wr_pair     = ptr_eff[5:1];

    assign wr.lo_we = data_wr && !ptr_eff[0];
    assign wr.hi_we = data_wr && ptr_eff[0];
    assign wr.data  = item.write_data;
    assign wr_addr  = obj_side ? (AW'(PAIRS) + AW'(wr_pair)) : AW'(wr_pair);

    // Next state of pointers, shade map and valid bits.
    always_comb
    begin
        bg_ptr_next   = bg_ptr_reg;
        obj_ptr_next  = obj_ptr_reg;
        bg_inc_next   = bg_inc_reg;
        obj_inc_next  = obj_inc_reg;
        shade_next    = shade_reg;
        lo_valid_next = lo_valid_reg;
        hi_valid_next = hi_valid_reg;
        if (is_write)
        begin
            case (sel)
                ipr_pkg::SEL_BG_SHADE:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        shade_next[0][c] = item.write_data[2*c +: 2];
                    end
                end
                ipr_pkg::SEL_OBJ0_SHADE:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        shade_next[1][c] = item.write_data[2*c +: 2];
                    end
                    shade_next[1][0] = 2'd0;
                end
                ipr_pkg::SEL_OBJ1_SHADE:
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        shade_next[2][c] = item.write_data[2*c +: 2];
                    end
                    shade_next[2][0] = 2'd0;
                end
                ipr_pkg::SEL_BG_INDEX:
                begin
                    bg_ptr_next = {1'b0, item.write_data[5:0]};
                    bg_inc_next = item.write_data[7];
                end
                ipr_pkg::SEL_OBJ_INDEX:
                begin
                    obj_ptr_next = {1'b0, item.write_data[5:0]};
                    obj_inc_next = item.write_data[7];
                end
                ipr_pkg::SEL_BG_DATA:
                begin
                    bg_ptr_next = inc_sel ? (ptr_eff + 1'b1) : ptr_eff;
                end
                ipr_pkg::SEL_OBJ_DATA:
                begin
                    obj_ptr_next = inc_sel ? (ptr_eff + 1'b1) : ptr_eff;
                end
                default:
                begin
                end
            endcase
            if (wr.lo_we)
            begin
                lo_valid_next[wr_addr] = 1'b1;
            end
            if (wr.hi_we)
            begin
                hi_valid_next[wr_addr] = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_ptr_reg   <= '0;
            obj_ptr_reg  <= '0;
            bg_inc_reg   <= 1'b0;
            obj_inc_reg  <= 1'b0;
            lo_valid_reg <= '0;
            hi_valid_reg <= '0;
            for (int p = 0; p < 3; p++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    shade_reg[p][c] <= 2'(c);
                end
            end
        end
        else
        begin
            bg_ptr_reg   <= bg_ptr_next;
            obj_ptr_reg  <= obj_ptr_next;
            bg_inc_reg   <= bg_inc_next;
            obj_inc_reg  <= obj_inc_next;
            lo_valid_reg <= lo_valid_next;
            hi_valid_reg <= hi_valid_next;
            shade_reg    <= shade_next;
        end
    end

    // Lookup address: palette bit 3 picks the bank, the rest picks the pair.
    assign lk_pair     = {item.palette_number[2:0], item.color_index};
    assign lk_in_range = ({1'b0, lk_pair} < 6'(PAIRS));
    assign rd_addr     = !lk_in_range ? '0 :
                         item.palette_number[3] ? (AW'(PAIRS) + AW'(lk_pair)) :
                         AW'(lk_pair);

    // Monochrome palettes above 2 read palette 2.
    assign mono_pal = (item.palette_number > 4'd2) ? 2'd2 : item.palette_number[1:0];

    // A pair with neither byte written still reads as white.
    assign info.is_lookup = (item.op == ipr_pkg::OP_LOOKUP);
    assign info.color     = color_mode_reg;
    assign info.lo_ok     = lk_in_range && lo_valid_reg[rd_addr];
    assign info.hi_ok     = lk_in_range && hi_valid_reg[rd_addr];
    assign info.white     = !(info.lo_ok || info.hi_ok);
    assign info.shade     = shade_reg[mono_pal][item.color_index];

    // The pointers never go past PTR_MAX, the end of a full-size RAM.
    `IPR_ASSERT(a_bg_ptr_bound, (bg_ptr_reg <= ipr_pkg::PTR_W'(ipr_pkg::PTR_MAX)))
    `IPR_ASSERT(a_obj_ptr_bound, (obj_ptr_reg <= ipr_pkg::PTR_W'(ipr_pkg::PTR_MAX)))
    // A data write stores exactly one byte of a pair.
    `IPR_ASSERT(a_one_byte, !(wr.lo_we && wr.hi_we))
    // RAM writes happen only as a word leaves the input register.
    `IPR_ASSERT(a_write_on_fire, (wr.lo_we || wr.hi_we) |-> fire)

endmodule

### hw/rtl/ipr_out.sv
// Result path: lookup side register aligned with the RAM read, color
// formatting and the result register. Depends on ipr_pkg, ipr_if, macros.
`include "assert_macros.svh"

module ipr_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ipr_pkg::lkup_t info,
    input  logic [7:0]     lo_data,
    input  logic [6:0]     hi_data,
    ipr_rsp_if.source      rsp
);

    logic           s2_valid_reg, s2_valid_next;
    ipr_pkg::lkup_t s2_info_reg;
    logic           out_valid_reg, out_valid_next;
    logic [4:0]     red_reg, green_reg, blue_reg;
    logic [1:0]     shade_reg;
    logic           s3_ready;
    logic           load2;
    logic           load3;
    logic [7:0]     lo_m;
    logic [6:0]     hi_m;
    ipr_pkg::rgb_t  rgb;
    ipr_pkg::rgb_t  rgb_next;
    logic [1:0]     shade_next;

    // Stage handshakes.
    assign s3_ready = !out_valid_reg || rsp.ready;
    assign in_ready = !s2_valid_reg || s3_ready;
    assign load2    = in_valid && in_ready;
    assign load3    = s2_valid_reg && s3_ready;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (load2)
        begin
            s2_valid_next = 1'b1;
        end
        else if (load3)
        begin
            s2_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load3)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Side information moves together with the RAM read data.
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_info_reg <= info;
        end
    end

    // Unwritten bytes read as zero; writes give an all-zero result.
    assign lo_m = s2_info_reg.lo_ok ? lo_data : 8'd0;
    assign hi_m = s2_info_reg.hi_ok ? hi_data : 7'd0;
    assign rgb  = ipr_pkg::decode_pair(lo_m, hi_m);

    always_comb
    begin
        rgb_next   = '0;
        shade_next = 2'd0;
        if (s2_info_reg.is_lookup)
        begin
            if (s2_info_reg.color)
            begin
                if (s2_info_reg.white)
                begin
                    rgb_next.r = ipr_pkg::CHAN_FULL;
                    rgb_next.g = ipr_pkg::CHAN_FULL;
                    rgb_next.b = ipr_pkg::CHAN_FULL;
                end
                else
                begin
                    rgb_next = rgb;
                end
            end
            else
            begin
                shade_next = s2_info_reg.shade;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            red_reg   <= rgb_next.r;
            green_reg <= rgb_next.g;
            blue_reg  <= rgb_next.b;
            shade_reg <= shade_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.red   = red_reg;
    assign rsp.green = green_reg;
    assign rsp.blue  = blue_reg;
    assign rsp.shade = shade_reg;

    // A result word always comes from a word held in the RAM read stage.
    `IPR_ASSERT(a_out_from_s2, $rose(out_valid_reg) |-> $past(s2_valid_reg))
    // A word waiting in the read stage is not dropped.
    `IPR_ASSERT(a_s2_holds, (s2_valid_reg && !load3) |=> s2_valid_reg)
    // Shade and color never appear in the same result word.
    `IPR_ASSERT(a_shade_or_color, (out_valid_reg && (shade_reg != 2'd0)) |-> (red_reg == 5'd0 && green_reg == 5'd0 && blue_reg == 5'd0))

endmodule

### hw/rtl/indexed_palette_ram_unit_top.sv
// Top level of the indexed palette RAM unit: input register, control,
// byte RAMs and result path. Depends on ipr_pkg, ipr_if, ipr_ram, ipr_ctrl, ipr_out.
//
//   channel  role    moves
//   req      sink    one register write or pixel lookup word
//   rsp      source  one result word (red, green, blue, shade) per request
//   cfg      sink    color_mode register write, always ready
//
// One word is accepted every cycle while the result is not stalled; its result
// passes the input register, the palette RAM read register and the result register.
// The palette bytes sit in two RAMs, one for low and one for high bytes of
// each color pair, so a data write is a single RAM write with no read.
// After reset the unit is ready at once: per-byte valid bits stand in for
// the cleared RAM and for the all-white color table.
// A stalled result holds each stage in turn; bubbles are squeezed out.
module indexed_palette_ram_unit_top #(
    parameter int PALETTE_BYTES = ipr_pkg::PALETTE_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ipr_req_if.sink   req,
    ipr_rsp_if.source rsp,
    ipr_cfg_if.sink   cfg
);

    localparam int PAIRS = (PALETTE_BYTES + 1) / 2;
    localparam int DEPTH = 2 * PAIRS;
    localparam int AW = $clog2(DEPTH);

    logic             s1_valid_reg, s1_valid_next;
    ipr_pkg::item_t   s1_item_reg;
    logic             s2_ready;
    logic             s1_fire;
    logic             req_fire;
    ipr_pkg::ram_wr_t wr;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    ipr_pkg::lkup_t   info;
    logic [7:0]       lo_data;
    logic [6:0]       hi_data;

    // Input register.
    assign req.ready = !s1_valid_reg || s2_ready;
    assign req_fire  = req.valid && req.ready;
    assign s1_fire   = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg.op             <= req.op;
            s1_item_reg.reg_select     <= req.reg_select;
            s1_item_reg.write_data     <= req.write_data;
            s1_item_reg.palette_number <= req.palette_number;
            s1_item_reg.color_index    <= req.color_index;
        end
    end

    // Register file and address decode.
    ipr_ctrl #(
        .PALETTE_BYTES (PALETTE_BYTES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (s1_fire),
        .item    (s1_item_reg),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .info    (info)
    );

    // Low bytes of each color pair.
    ipr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_lo_ram (
        .clk   (clk),
        .we    (wr.lo_we),
        .waddr (wr_addr),
        .wdata (wr.data),
        .re    (s1_fire),
        .raddr (rd_addr),
        .rdata (lo_data)
    );

    // High bytes of each color pair; the top bit never reaches a color.
    ipr_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_hi_ram (
        .clk   (clk),
        .we    (wr.hi_we),
        .waddr (wr_addr),
        .wdata (wr.data[6:0]),
        .re    (s1_fire),
        .raddr (rd_addr),
        .rdata (hi_data)
    );

    // Result formatting and output register.
    ipr_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_ready (s2_ready),
        .info     (info),
        .lo_data  (lo_data),
        .hi_data  (hi_data),
        .rsp      (rsp)
    );

endmodule
